[design/rwicp_pkg.sv]
package rwicp_pkg;

   localparam int DEF_NUM_CLASSES = 8;
   localparam int DEF_ADDR_BITS   = 20;
   localparam int DEF_TIME_BITS   = 40;

   localparam int CNT_W  = 18;
   localparam int EW_W   = 25;
   localparam int SEG_W  = 18;
   localparam int ESEG_W = 8;
   localparam int CSR_W  = 1;

   localparam logic [CSR_W-1:0]  CSR_SEGMENT = 1'd0;
   localparam logic [CSR_W-1:0]  CSR_EPOCH   = 1'd1;
   localparam logic [SEG_W-1:0]  SEG_RESET   = 18'd131072;
   localparam logic [ESEG_W-1:0] EPOCH_RESET = 8'd128;
   localparam logic [EW_W-1:0]   EW_MAX      = {EW_W{1'b1}};

   typedef struct packed {
      logic load;
      logic clear;
      logic mem_rd;
      logic calc;
      logic scan;
      logic add;
      logic div;
      logic commit;
      logic epoch;
      logic split_start;
      logic split_scan;
      logic split_fin;
      logic merge;
      logic out;
   } ctl_cmd_type;

   typedef struct packed {
      logic gc;
      logic seal;
      logic epoch_due;
      logic split_go;
      logic rsp_free;
   } dp_sts_type;

endpackage

[design/rwicp_dp.sv]
module rwicp_dp import rwicp_pkg::*; #(
   parameter int NUM_CLASSES = DEF_NUM_CLASSES,
   parameter int ADDR_BITS   = DEF_ADDR_BITS,
   parameter int TIME_BITS   = DEF_TIME_BITS,
   localparam int CLS_BITS   = $clog2(NUM_CLASSES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   input  logic [CLS_BITS-1:0]  idx,
   input  logic [ADDR_BITS-1:0] clr_addr,
   output dp_sts_type           sts,
   input  logic                 req_command,
   input  logic [ADDR_BITS-1:0] req_block_addr,
   input  logic [TIME_BITS-1:0] req_timestamp,
   input  logic                 csr_we,
   input  logic [CSR_W-1:0]     csr_addr,
   input  logic [SEG_W-1:0]     csr_wdata,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [CLS_BITS-1:0]  rsp_class_id,
   output logic [TIME_BITS-1:0] rsp_interval
);

   localparam int CW   = TIME_BITS + 16;
   localparam int WSW  = TIME_BITS + 18;
   localparam int DIVW = WSW + 16;
   localparam int ENTW = 2 * TIME_BITS + 1;

   logic [SEG_W-1:0]     seg_ff;
   logic [ESEG_W-1:0]    eseg_ff;
   logic                 cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [ENTW-1:0]      rd_ff;
   logic [ENTW-1:0]      mem [2**ADDR_BITS];
   logic [TIME_BITS-1:0] rwi_ff;

   logic [CW-1:0]    center_ff [NUM_CLASSES];
   logic             closed_ff [NUM_CLASSES];
   logic [WSW-1:0]   wsum_ff   [NUM_CLASSES];
   logic [CNT_W-1:0] cnt_ff    [NUM_CLASSES];
   logic [EW_W-1:0]  ew_ff     [NUM_CLASSES];
   logic             pend_ff   [NUM_CLASSES];
   logic [EW_W-1:0]  total_ff;
   logic [ESEG_W-1:0] sealed_ff;

   logic                best_valid_ff;
   logic [CW-1:0]       best_ff;
   logic [CLS_BITS-1:0] best_t_ff;
   logic [CLS_BITS-1:0] t_ff;
   logic [DIVW-1:0]     dq_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [CNT_W-1:0]    dv_ff;
   logic                seal_ff;
   logic                due_ff;
   logic                allow_ff;
   logic                found_ff;
   logic [CLS_BITS-1:0] k_ff;
   logic [CLS_BITS-1:0] dst_ff;
   logic [CW-1:0]       c_ff;
   logic                have_eq_ff;
   logic                have_lo_ff;
   logic                have_hi_ff;
   logic [CW-1:0]       lo_ff;
   logic [CW-1:0]       hi_ff;
   logic                rsp_valid_ff;
   logic [CLS_BITS-1:0] rsp_cls_ff;
   logic [TIME_BITS-1:0] rsp_int_ff;

   logic [TIME_BITS-1:0] prev;
   logic [TIME_BITS-1:0] pen;
   logic                 written;
   logic [TIME_BITS-1:0] diff;
   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] rwi_calc;
   logic [ENTW-1:0]      new_ent;

   always_comb begin
      prev     = rd_ff[TIME_BITS-1:0];
      written  = rd_ff[TIME_BITS];
      pen      = rd_ff[ENTW-1:TIME_BITS+1];
      diff     = (now_ff >= prev) ? now_ff - prev : '0;
      sum      = {1'b0, diff} + {1'b0, pen};
      rwi_calc = '0;
      if (!cmd_ff && written) begin
         rwi_calc = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
      end
      if (cmd_ff) begin
         new_ent = {(written ? diff : {TIME_BITS{1'b0}}), rd_ff[TIME_BITS:0]};
      end else begin
         new_ent = {{TIME_BITS{1'b0}}, 1'b1, now_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_addr] <= '0;
      end else if (cmd.calc) begin
         mem[addr_ff] <= new_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_ff <= mem[addr_ff];
      end
   end

   logic [CW-1:0] target;
   logic [CW-1:0] cv;
   logic [CW-1:0] gap;
   logic          better;

   always_comb begin
      target = {rwi_ff, 16'b0};
      cv     = center_ff[idx];
      gap    = (cv > target) ? cv - target : target - cv;
      better = !closed_ff[idx] && (!best_valid_ff || gap < best_ff);
   end

   logic [CLS_BITS-1:0] t_eff;
   logic [WSW-1:0]      wsum_new;
   logic [CNT_W-1:0]    cnt_new;
   logic [CNT_W:0]      trial;
   logic                ge;
   logic [CW-1:0]       qsat;
   logic                seal;
   logic [ESEG_W-1:0]   sealed_nx;

   always_comb begin
      t_eff     = best_valid_ff ? best_t_ff : CLS_BITS'(1);
      wsum_new  = wsum_ff[t_eff] + WSW'(rwi_ff);
      cnt_new   = cnt_ff[t_eff] + 1'b1;
      trial     = {rem_ff, dq_ff[DIVW-1]};
      ge        = trial >= {1'b0, dv_ff};
      qsat      = (|dq_ff[DIVW-1:CW]) ? '1 : dq_ff[CW-1:0];
      seal      = cnt_ff[t_ff] >= seg_ff;
      sealed_nx = sealed_ff + 1'b1;
   end

   logic [EW_W-1:0]     half;
   logic                found;
   logic [CLS_BITS-1:0] k_sel;
   logic                allow;
   logic                dst_valid;
   logic [CLS_BITS-1:0] dst_sel;

   always_comb begin
      half      = total_ff >> 1;
      found     = 1'b0;
      k_sel     = '0;
      allow     = 1'b0;
      dst_valid = 1'b0;
      dst_sel   = '0;
      for (int i = NUM_CLASSES - 1; i >= 1; i--) begin
         if (ew_ff[i] > half) begin
            found = 1'b1;
            k_sel = CLS_BITS'(i);
         end
      end
      for (int i = 1; i < NUM_CLASSES; i++) begin
         if (closed_ff[i] || (ew_ff[i] < EW_W'(seg_ff) && cnt_ff[i] == '0)) begin
            allow = 1'b1;
         end
         if (closed_ff[i]) begin
            dst_valid = 1'b1;
            dst_sel   = CLS_BITS'(i);
         end
      end
   end

   logic [CW-1:0] sv;
   logic          sconsider;
   logic [CW-1:0] left;
   logic [CW:0]   two_c_left;
   logic [CW:0]   right;
   logic [CW+1:0] csum;
   logic [CW-1:0] nc;

   always_comb begin
      sv         = center_ff[idx];
      sconsider  = !closed_ff[idx] && (idx != k_ff);
      left       = have_eq_ff ? c_ff : (have_lo_ff ? lo_ff : '0);
      two_c_left = {c_ff, 1'b0} - {1'b0, left};
      right      = have_hi_ff ? {1'b0, hi_ff} : two_c_left;
      csum       = {2'b0, c_ff} + {1'b0, right};
      nc         = csum[CW+1] ? '1 : csum[CW:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff  <= SEG_RESET;
         eseg_ff <= EPOCH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SEGMENT: seg_ff  <= csr_wdata;
            CSR_EPOCH:   eseg_ff <= csr_wdata[ESEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_command;
         addr_ff <= req_block_addr;
         now_ff  <= req_timestamp;
      end
      if (cmd.calc) begin
         rwi_ff        <= rwi_calc;
         best_valid_ff <= 1'b0;
      end
      if (cmd.scan && better) begin
         best_valid_ff <= 1'b1;
         best_ff       <= gap;
         best_t_ff     <= idx;
      end
      if (cmd.add) begin
         t_ff   <= t_eff;
         dq_ff  <= {wsum_new, 16'b0};
         rem_ff <= '0;
         dv_ff  <= (cnt_new == '0) ? CNT_W'(1) : cnt_new;
      end
      if (cmd.div) begin
         rem_ff <= ge ? CNT_W'(trial - {1'b0, dv_ff}) : trial[CNT_W-1:0];
         dq_ff  <= {dq_ff[DIVW-2:0], ge};
      end
      if (cmd.commit) begin
         seal_ff <= seal;
         due_ff  <= sealed_nx >= eseg_ff;
      end
      if (cmd.epoch) begin
         allow_ff <= allow;
         found_ff <= found;
         k_ff     <= k_sel;
      end
      if (cmd.split_start) begin
         dst_ff     <= dst_sel;
         c_ff       <= center_ff[k_ff];
         have_eq_ff <= 1'b0;
         have_lo_ff <= 1'b0;
         have_hi_ff <= 1'b0;
      end
      if (cmd.split_scan && sconsider) begin
         if (sv == c_ff) begin
            have_eq_ff <= 1'b1;
         end else if (sv < c_ff) begin
            if (!have_lo_ff || sv > lo_ff) begin
               lo_ff      <= sv;
               have_lo_ff <= 1'b1;
            end
         end else begin
            if (!have_hi_ff || sv < hi_ff) begin
               hi_ff      <= sv;
               have_hi_ff <= 1'b1;
            end
         end
      end
      if (cmd.out) begin
         rsp_cls_ff <= cmd_ff ? '0 : t_ff;
         rsp_int_ff <= rwi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            center_ff[i] <= '0;
            closed_ff[i] <= (i == 0);
            wsum_ff[i]   <= '0;
            cnt_ff[i]    <= '0;
            ew_ff[i]     <= '0;
            pend_ff[i]   <= 1'b0;
         end
         total_ff     <= '0;
         sealed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.add) begin
            closed_ff[t_eff] <= 1'b0;
            wsum_ff[t_eff]   <= wsum_new;
            cnt_ff[t_eff]    <= cnt_new;
         end
         if (cmd.commit) begin
            center_ff[t_ff] <= qsat;
            ew_ff[t_ff]     <= (ew_ff[t_ff] == EW_MAX) ? EW_MAX : ew_ff[t_ff] + 1'b1;
            total_ff        <= (total_ff == EW_MAX) ? EW_MAX : total_ff + 1'b1;
            if (seal) begin
               cnt_ff[t_ff]  <= '0;
               wsum_ff[t_ff] <= '0;
               sealed_ff     <= sealed_nx;
            end
         end
         if (cmd.epoch) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
               pend_ff[i] <= 1'b0;
               ew_ff[i]   <= '0;
               if (i != 0 && ew_ff[i] < EW_W'(seg_ff)) begin
                  if (cnt_ff[i] == '0) begin
                     closed_ff[i] <= 1'b1;
                  end else begin
                     pend_ff[i] <= 1'b1;
                  end
               end
            end
            total_ff  <= '0;
            sealed_ff <= '0;
         end
         if (cmd.split_fin) begin
            center_ff[dst_ff] <= nc;
            closed_ff[dst_ff] <= 1'b0;
         end
         if (cmd.merge && pend_ff[t_ff]) begin
            closed_ff[t_ff] <= 1'b1;
            pend_ff[t_ff]   <= 1'b0;
         end
         if (cmd.out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.gc        = cmd_ff;
      sts.seal      = seal_ff;
      sts.epoch_due = due_ff;
      sts.split_go  = allow_ff && found_ff && dst_valid && !closed_ff[k_ff];
      sts.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_class_id = rsp_cls_ff;
   assign rsp_interval = rsp_int_ff;

endmodule

[design/rwicp_ctrl.sv]
module rwicp_ctrl import rwicp_pkg::*; #(
   parameter int NUM_CLASSES = DEF_NUM_CLASSES,
   parameter int ADDR_BITS   = DEF_ADDR_BITS,
   parameter int TIME_BITS   = DEF_TIME_BITS,
   localparam int CLS_BITS   = $clog2(NUM_CLASSES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  dp_sts_type           sts,
   output ctl_cmd_type          cmd,
   output logic [CLS_BITS-1:0]  idx,
   output logic [ADDR_BITS-1:0] clr_addr
);

   localparam int DIVW   = TIME_BITS + 34;
   localparam int DCNT_W = $clog2(DIVW);

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_READ       = 4'd2;
   localparam logic [3:0] S_CALC       = 4'd3;
   localparam logic [3:0] S_SCAN       = 4'd4;
   localparam logic [3:0] S_ADD        = 4'd5;
   localparam logic [3:0] S_DIV        = 4'd6;
   localparam logic [3:0] S_COMMIT     = 4'd7;
   localparam logic [3:0] S_DECIDE     = 4'd8;
   localparam logic [3:0] S_EPOCH      = 4'd9;
   localparam logic [3:0] S_SPLIT_CHK  = 4'd10;
   localparam logic [3:0] S_SPLIT_SCAN = 4'd11;
   localparam logic [3:0] S_SPLIT_FIN  = 4'd12;
   localparam logic [3:0] S_MERGE      = 4'd13;
   localparam logic [3:0] S_OUT        = 4'd14;

   localparam logic [CLS_BITS-1:0] LAST_CLS = CLS_BITS'(NUM_CLASSES - 1);
   localparam logic [DCNT_W-1:0]   LAST_DIV = DCNT_W'(DIVW - 1);

   logic [3:0]           state_ff, state_in;
   logic [CLS_BITS-1:0]  idx_ff, idx_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      dcnt_in    = dcnt_ff;
      clr_in     = clr_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            idx_in   = CLS_BITS'(1);
            state_in = sts.gc ? S_OUT : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == LAST_CLS) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div = 1'b1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == LAST_DIV) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            if (!sts.seal) begin
               state_in = S_OUT;
            end else if (sts.epoch_due) begin
               state_in = S_EPOCH;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_EPOCH: begin
            cmd.epoch = 1'b1;
            state_in  = S_SPLIT_CHK;
         end
         S_SPLIT_CHK: begin
            cmd.split_start = 1'b1;
            idx_in          = CLS_BITS'(1);
            state_in        = sts.split_go ? S_SPLIT_SCAN : S_MERGE;
         end
         S_SPLIT_SCAN: begin
            cmd.split_scan = 1'b1;
            idx_in         = idx_ff + 1'b1;
            if (idx_ff == LAST_CLS) begin
               state_in = S_SPLIT_FIN;
            end
         end
         S_SPLIT_FIN: begin
            cmd.split_fin = 1'b1;
            state_in      = S_MERGE;
         end
         S_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.out  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         idx_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         idx_ff   <= idx_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   assign idx      = idx_ff;
   assign clr_addr = clr_ff;

endmodule

[design/rewrite_interval_cluster_placement.sv]
// Channel   Direction  Fields
// req_      in         tuser: command; tdata: block_addr, timestamp
// rsp_      out        tdata: class_id, interval
// csr_      in         index 0 segment_blocks, index 1 epoch_segments
//
// A user write runs the class scans and the one-bit-per-cycle mean divider; a sealing
// write adds a merge step, preceded by the epoch pass when an epoch is due. A GC append
// skips the scans and the divider.
// After reset the address memory is cleared before req_tready rises.
// A result waits in the output register while the next transaction is taken.
module rewrite_interval_cluster_placement import rwicp_pkg::*; #(
   parameter int NUM_CLASSES = DEF_NUM_CLASSES,
   parameter int ADDR_BITS   = DEF_ADDR_BITS,
   parameter int TIME_BITS   = DEF_TIME_BITS,
   localparam int CLS_BITS   = $clog2(NUM_CLASSES),
   localparam int REQ_W      = ((ADDR_BITS + TIME_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((CLS_BITS + TIME_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // block_addr, timestamp
   input  logic             req_tuser,   // command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // class_id, interval
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_addr,
   input  logic [SEG_W-1:0] csr_wdata
);

   ctl_cmd_type          cmd;
   dp_sts_type           sts;
   logic [CLS_BITS-1:0]  idx;
   logic [ADDR_BITS-1:0] clr_addr;
   logic [CLS_BITS-1:0]  class_id;
   logic [TIME_BITS-1:0] interval;

   rwicp_ctrl #(
      .NUM_CLASSES(NUM_CLASSES),
      .ADDR_BITS  (ADDR_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd),
      .idx       (idx),
      .clr_addr  (clr_addr)
   );

   rwicp_dp #(
      .NUM_CLASSES(NUM_CLASSES),
      .ADDR_BITS  (ADDR_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .idx           (idx),
      .clr_addr      (clr_addr),
      .sts           (sts),
      .req_command   (req_tuser),
      .req_block_addr(req_tdata[ADDR_BITS-1:0]),
      .req_timestamp (req_tdata[ADDR_BITS+TIME_BITS-1:ADDR_BITS]),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_class_id  (class_id),
      .rsp_interval  (interval)
   );

   assign rsp_tdata = RSP_W'({interval, class_id});

endmodule

[dv/rewrite_interval_cluster_placement_tb.sv]
`timescale 1ns / 1ps

module rewrite_interval_cluster_placement_tb;
   import rwicp_pkg::*;

   localparam int NCLS = DEF_NUM_CLASSES;
   localparam int AW   = DEF_ADDR_BITS;
   localparam int TW   = DEF_TIME_BITS;
   localparam int CW   = $clog2(NCLS);
   localparam int REQ_W = ((AW + TW + 7) / 8) * 8;
   localparam int RSP_W = ((CW + TW + 7) / 8) * 8;
   localparam logic CMD_USER = 1'b0;
   localparam logic CMD_GC   = 1'b1;
   localparam logic [63:0] TMAX  = (64'd1 << TW) - 64'd1;
   localparam logic [63:0] CMASK = (64'd1 << (TW + 16)) - 64'd1;
   localparam logic [63:0] SMASK = (64'd1 << (TW + 18)) - 64'd1;
   localparam logic [63:0] EWMAX = (64'd1 << EW_W) - 64'd1;

   typedef struct packed {
      logic [CW-1:0] class_id;
      logic [TW-1:0] interval;
   } placement_type;

   typedef struct {
      logic          cmd;
      logic [AW-1:0] addr;
      logic [TW-1:0] ts;
      bit            typed;
      placement_type want;
   } write_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic [CSR_W-1:0] csr_addr;
   logic [SEG_W-1:0] csr_wdata;

   rewrite_interval_cluster_placement dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // placement predictor state
   bit [TW:0]     last_seen [bit [AW-1:0]];
   bit [TW-1:0]   penalty [bit [AW-1:0]];
   bit [63:0]     center [NCLS];
   bit            closed [NCLS];
   bit [63:0]     wsum [NCLS];
   bit [63:0]     bcount [NCLS];
   bit [63:0]     ewrites [NCLS];
   bit            merge_due [NCLS];
   bit [63:0]     ewrites_total;
   bit [63:0]     sealed;
   bit [63:0]     seg_blocks;
   bit [63:0]     epoch_len;

   placement_type placements_due [$];
   int            n_mismatch;
   int            n_results;
   int            n_sent;
   int            n_seals;
   int            n_epochs;
   int            idle_pct;
   int            stall_pct;
   bit            pressure_on;
   int            hold_left;
   int            hold_timer;
   logic [AW-1:0] pool [12];
   logic [TW-1:0] now_ts;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void split_busiest(int k);
      int        dst;
      bit [63:0] c, left, right, nc;
      bit        have_eq, have_lo, have_hi;
      dst = -1;
      c = center[k];
      left = 0;
      right = 0;
      have_eq = 0;
      have_lo = 0;
      have_hi = 0;
      for (int i = 1; i < NCLS; i++) if (closed[i]) dst = i;
      if (dst < 0 || closed[k]) return;
      for (int i = 1; i < NCLS; i++) begin
         if (closed[i] || i == k) continue;
         if (center[i] == c) have_eq = 1;
         else if (center[i] < c) begin
            if (!have_lo || center[i] > left) begin
               left = center[i];
               have_lo = 1;
            end
         end else begin
            if (!have_hi || center[i] < right) begin
               right = center[i];
               have_hi = 1;
            end
         end
      end
      if (have_eq) left = c;
      if (!have_hi) right = 2 * c - left;
      nc = (c + right) >> 1;
      if (nc > CMASK) nc = CMASK;
      center[dst] = nc;
      closed[dst] = 0;
   endfunction

   function automatic void run_epoch();
      bit allow;
      allow = 0;
      n_epochs++;
      for (int i = 1; i < NCLS; i++) if (closed[i]) allow = 1;
      for (int i = 0; i < NCLS; i++) merge_due[i] = 0;
      for (int i = 1; i < NCLS; i++) begin
         if (ewrites[i] < seg_blocks) begin
            if (bcount[i] == 0) begin
               closed[i] = 1;
               allow = 1;
            end else merge_due[i] = 1;
         end
      end
      if (allow) begin
         for (int i = 1; i < NCLS; i++) begin
            if (ewrites[i] > ewrites_total / 2) begin
               split_busiest(i);
               break;
            end
         end
      end
      sealed = 0;
      ewrites_total = 0;
      for (int i = 0; i < NCLS; i++) ewrites[i] = 0;
   endfunction

   function automatic int join_nearest(bit [63:0] rwi);
      bit [63:0] pos, best, d, q, r, cnt;
      int        t;
      pos = rwi << 16;
      best = 0;
      t = -1;
      for (int i = 1; i < NCLS; i++) begin
         if (closed[i]) continue;
         d = (center[i] > pos) ? center[i] - pos : pos - center[i];
         if (t < 0 || d < best) begin
            best = d;
            t = i;
         end
      end
      if (t < 0) begin
         t = 1;
         closed[1] = 0;
      end
      wsum[t] = (wsum[t] + rwi) & SMASK;
      bcount[t] = (bcount[t] + 1) & 64'h3FFFF;
      cnt = (bcount[t] == 0) ? 64'd1 : bcount[t];
      q = wsum[t] / cnt;
      r = wsum[t] % cnt;
      q = (q << 16) | ((r << 16) / cnt);
      center[t] = (q > CMASK) ? CMASK : q;
      ewrites[t] = (ewrites[t] < EWMAX) ? ewrites[t] + 1 : EWMAX;
      ewrites_total = (ewrites_total < EWMAX) ? ewrites_total + 1 : EWMAX;
      if (bcount[t] >= seg_blocks) begin
         n_seals++;
         bcount[t] = 0;
         wsum[t] = 0;
         sealed = (sealed + 1) & 64'hFF;
         if (sealed >= epoch_len) run_epoch();
         if (merge_due[t]) begin
            closed[t] = 1;
            merge_due[t] = 0;
         end
      end
      return t;
   endfunction

   function automatic placement_type predict_placement(logic cmd, logic [AW-1:0] a,
                                                        logic [TW-1:0] ts);
      placement_type p;
      bit [TW:0]     entry;
      bit [63:0]     diff, rwi;
      entry = last_seen.exists(a) ? last_seen[a] : '0;
      diff = (ts >= entry[TW-1:0]) ? ts - entry[TW-1:0] : 64'd0;
      rwi = 0;
      p = '0;
      if (cmd == CMD_GC) begin
         penalty[a] = entry[TW] ? diff[TW-1:0] : '0;
      end else begin
         if (entry[TW]) begin
            rwi = diff + (penalty.exists(a) ? penalty[a] : '0);
            if (rwi > TMAX) rwi = TMAX;
         end
         last_seen[a] = {1'b1, ts};
         penalty[a] = '0;
         p.class_id = CW'(join_nearest(rwi));
      end
      p.interval = rwi[TW-1:0];
      return p;
   endfunction

   task automatic send_write(logic cmd, logic [AW-1:0] a, logic [TW-1:0] ts,
                             bit typed, placement_type want);
      placement_type p;
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= REQ_W'({ts, a});
      do @(posedge clock); while (!req_tready);
      p = predict_placement(cmd, a, ts);
      placements_due = {placements_due, (typed ? want : p)};
      n_sent++;
   endtask

   task automatic drain(int settle);
      req_tvalid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_W-1:0] idx, logic [SEG_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_SEGMENT) seg_blocks = val;
      else epoch_len = val[ESEG_W-1:0];
   endtask

   task automatic random_write();
      int            r;
      logic          cmd;
      logic [AW-1:0] a;
      logic [TW-1:0] ts;
      r = $urandom_range(99);
      a = pool[$urandom_range(11)];
      cmd = (r < 18) ? CMD_GC : CMD_USER;
      case ($urandom_range(9))
         0: now_ts = now_ts - TW'($urandom_range(1000));
         1: now_ts = now_ts + TW'({$urandom, $urandom} >> $urandom_range(24, 63));
         default: now_ts = now_ts + TW'($urandom_range(5000));
      endcase
      ts = now_ts;
      if (r >= 88) begin
         a = AW'($urandom);
         ts = TW'({$urandom, $urandom});
      end
      send_write(cmd, a, ts, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         hold_timer <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_on && hold_timer >= 2000) begin
         rsp_tready <= 1'b0;
         hold_left <= 700;
         hold_timer <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         hold_timer <= hold_timer + 1;
      end
   end

   always @(posedge clock) begin
      placement_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.class_id = rsp_tdata[CW-1:0];
         got.interval = rsp_tdata[CW+TW-1:CW];
         n_results++;
         if (placements_due.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("unexpected transaction: class %0d interval %0d",
                        got.class_id, got.interval);
         end else begin
            want = placements_due.pop_front();
            if (got.class_id !== want.class_id || got.interval !== want.interval) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch at %0d: class exp %0d got %0d, interval exp %0d got %0d",
                           n_results, want.class_id, got.class_id,
                           want.interval, got.interval);
            end
         end
      end
   end

   initial begin
      write_row_type rows [$];
      int            seg_set [7];
      int            ep_set [7];
      int            limit;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      pressure_on = 0;
      n_mismatch = 0;
      n_results = 0;
      n_sent = 0;
      n_seals = 0;
      n_epochs = 0;
      now_ts = 0;
      for (int i = 0; i < NCLS; i++) begin
         center[i] = 0;
         closed[i] = (i == 0);
         wsum[i] = 0;
         bcount[i] = 0;
         ewrites[i] = 0;
         merge_due[i] = 0;
      end
      ewrites_total = 0;
      sealed = 0;
      seg_blocks = SEG_RESET;
      epoch_len = EPOCH_RESET;
      for (int i = 0; i < 12; i++) pool[i] = AW'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      rows = '{
         '{CMD_USER, 20'h00000, 40'd0,           1, '{3'd1, 40'd0}},
         '{CMD_GC,   20'h00000, 40'd5,           1, '{3'd0, 40'd0}},
         '{CMD_GC,   20'h00001, 40'd100,         1, '{3'd0, 40'd0}},
         '{CMD_USER, 20'h00000, 40'd10,          0, '{3'd0, 40'd0}},
         '{CMD_USER, 20'hFFFFF, TW'(TMAX),       0, '{3'd0, 40'd0}},
         '{CMD_USER, 20'hFFFFF, 40'd0,           0, '{3'd0, 40'd0}},
         '{CMD_USER, 20'h00002, 40'd0,           0, '{3'd0, 40'd0}},
         '{CMD_GC,   20'h00002, TW'(TMAX),       1, '{3'd0, 40'd0}},
         '{CMD_USER, 20'h00002, TW'(TMAX),       0, '{3'd0, 40'd0}},
         '{CMD_USER, 20'h00002, TW'(TMAX),       0, '{3'd0, 40'd0}},
         '{CMD_GC,   20'hFFFFF, 40'hAAAAAAAAAA,  1, '{3'd0, 40'd0}},
         '{CMD_USER, 20'h55555, 40'h5555555555,  0, '{3'd0, 40'd0}},
         '{CMD_USER, 20'h55555, 40'h5555555600,  0, '{3'd0, 40'd0}},
         '{CMD_USER, 20'hAAAAA, 40'd77,          0, '{3'd0, 40'd0}}
      };
      foreach (rows[i])
         send_write(rows[i].cmd, rows[i].addr, rows[i].ts, rows[i].typed, rows[i].want);
      drain(120);

      seg_set = '{4, 1, 0, 3, 262143, 2, 6};
      ep_set  = '{2, 1, 255, 0, 3, 1, 4};
      for (int ph = 0; ph < 7; ph++) begin
         write_csr(CSR_SEGMENT, SEG_W'(seg_set[ph]));
         write_csr(CSR_EPOCH, SEG_W'(ep_set[ph]));
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         pressure_on <= (ph == 0);
         limit = (ph == 4) ? 60 : 125;
         for (int n = 0; n < limit; n++) random_write();
         drain(120);
      end

      $display("sent %0d writes, %0d placements checked, %0d segment seals, %0d epoch passes",
               n_sent, n_results, n_seals, n_epochs);
      $display("configurations covered segment sizes 0 to 262143 and epoch lengths 0 to 255");
      if (n_mismatch == 0 && placements_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
